@@ sv/ctpc_pkg.sv @@
// shared types and constants for the timed curtain position controller
// no dependencies; imported by the interfaces and all modules
package ctpc_pkg;

	localparam int ACT_W  = 3;
	localparam int GEST_W = 2;
	localparam int TVAL_W = 8;
	localparam int MOT_W  = 2;
	localparam int PCT_W  = 7;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;
	localparam logic [PCT_W-1:0] HOME_PCT = 7'd50;
	localparam logic [PCT_W-1:0] OPEN_PCT = 7'd0;

	localparam logic [PCT_W-1:0] UP_STEP_RST   = 7'd10;
	localparam logic [PCT_W-1:0] DOWN_STEP_RST = 7'd12;
	localparam logic             LED_EN_RST    = 1'b1;

	// register indexes (word address)
	localparam logic [1:0] REG_UP_STEP   = 2'd0;
	localparam logic [1:0] REG_DOWN_STEP = 2'd1;
	localparam logic [1:0] REG_LED_EN    = 2'd2;

	// button gestures
	localparam logic [GEST_W-1:0] GEST_TAP   = 2'd0;
	localparam logic [GEST_W-1:0] GEST_PRESS = 2'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK   = 3'd0,
		ACT_UP     = 3'd1,
		ACT_DOWN   = 3'd2,
		ACT_SET    = 3'd3,
		ACT_RESET  = 3'd4
	} action_t;

	typedef enum logic [MOT_W-1:0] {
		MOT_STOP  = 2'd0,
		MOT_RAISE = 2'd1,
		MOT_LOWER = 2'd2
	} motion_t;

	typedef struct packed {
		logic [PCT_W-1:0] up_step;
		logic [PCT_W-1:0] down_step;
		logic             led_enable;
	} cfg_t;

	typedef struct packed {
		motion_t          motion;
		logic [PCT_W-1:0] position;
		logic [PCT_W-1:0] target;
		logic             led;
	} state_t;

endpackage

@@ sv/ctpc_if.sv @@
// item channels of the curtain controller: command in, status result out
// depends on ctpc_pkg for field widths
interface ctpc_in_if import ctpc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [GEST_W-1:0] gesture;
	logic [TVAL_W-1:0] target_value;

	modport source (output valid, action, gesture, target_value, input ready);
	modport sink (input valid, action, gesture, target_value, output ready);
endinterface

interface ctpc_out_if import ctpc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [MOT_W-1:0] motion;
	logic             drive_a;
	logic             drive_b;
	logic             led_on;
	logic [PCT_W-1:0] position;
	logic [PCT_W-1:0] target;

	modport source (output valid, motion, drive_a, drive_b, led_on, position, target,
		input ready);
	modport sink (input valid, motion, drive_a, drive_b, led_on, position, target,
		output ready);
endinterface

@@ sv/ctpc_regs.sv @@
// apb-style configuration registers: step sizes and led enable
// depends on ctpc_pkg
module ctpc_regs import ctpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_step    <= UP_STEP_RST;
			cfg_q.down_step  <= DOWN_STEP_RST;
			cfg_q.led_enable <= LED_EN_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_UP_STEP:   cfg_q.up_step    <= pwdata[PCT_W-1:0];
				REG_DOWN_STEP: cfg_q.down_step  <= pwdata[PCT_W-1:0];
				REG_LED_EN:    cfg_q.led_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3:2])
			REG_UP_STEP:   prdata = {{(DATA_W-PCT_W){1'b0}}, cfg_q.up_step};
			REG_DOWN_STEP: prdata = {{(DATA_W-PCT_W){1'b0}}, cfg_q.down_step};
			REG_LED_EN:    prdata = {{(DATA_W-1){1'b0}}, cfg_q.led_enable};
			default:       prdata = '0;
		endcase
	end

endmodule

@@ sv/ctpc_update.sv @@
// next-state logic: applies one command item to the motion/position state
// depends on ctpc_pkg
module ctpc_update import ctpc_pkg::*; (
	input  cfg_t              cfg,
	input  state_t            cur,
	input  logic [ACT_W-1:0]  action,
	input  logic [GEST_W-1:0] gesture,
	input  logic [TVAL_W-1:0] target_value,
	output state_t            nxt
);

	logic [PCT_W:0]   low_sum;
	logic [PCT_W:0]   raise_lim;
	logic             btn_go;
	logic [PCT_W-1:0] set_tgt;

	// tick arithmetic, one bit wider so nothing wraps
	assign low_sum   = {1'b0, cur.position} + {1'b0, cfg.down_step};
	assign raise_lim = {1'b0, cur.target} + {1'b0, cfg.up_step};

	// a tap acts only when stopped, a press always acts
	assign btn_go = (gesture == GEST_TAP && cur.motion == MOT_STOP) || gesture == GEST_PRESS;

	// saturate the requested target
	assign set_tgt = (target_value > {1'b0, FULL_PCT}) ? FULL_PCT : target_value[PCT_W-1:0];

	always_comb begin
		nxt = cur;
		case (action_t'(action))
			ACT_TICK: begin
				if (cur.motion == MOT_LOWER) begin
					if (low_sum >= {1'b0, cur.target}) begin
						nxt.position = cur.target;
						nxt.motion   = MOT_STOP;
						nxt.led      = 1'b0;
					end else begin
						nxt.position = low_sum[PCT_W-1:0];
					end
				end else if (cur.motion == MOT_RAISE) begin
					if ({1'b0, cur.position} <= raise_lim) begin
						nxt.position = cur.target;
						nxt.motion   = MOT_STOP;
						nxt.led      = 1'b0;
					end else begin
						nxt.position = cur.position - cfg.up_step;
					end
				end
			end
			ACT_UP: begin
				if (btn_go) begin
					nxt.target = OPEN_PCT;
					nxt.motion = MOT_RAISE;
					nxt.led    = cur.led | cfg.led_enable;
				end else begin
					nxt.motion = MOT_STOP;
					nxt.led    = 1'b0;
				end
			end
			ACT_DOWN: begin
				if (btn_go) begin
					nxt.target = FULL_PCT;
					nxt.motion = MOT_LOWER;
					nxt.led    = cur.led | cfg.led_enable;
				end else begin
					nxt.motion = MOT_STOP;
					nxt.led    = 1'b0;
				end
			end
			ACT_SET: begin
				nxt.target = set_tgt;
				if (set_tgt > cur.position) begin
					nxt.motion = MOT_LOWER;
					nxt.led    = cur.led | cfg.led_enable;
				end else if (set_tgt < cur.position) begin
					nxt.motion = MOT_RAISE;
					nxt.led    = cur.led | cfg.led_enable;
				end else begin
					nxt.motion = MOT_STOP;
					nxt.led    = 1'b0;
				end
			end
			ACT_RESET: begin
				nxt.position = HOME_PCT;
				nxt.target   = HOME_PCT;
				nxt.motion   = MOT_STOP;
				nxt.led      = 1'b0;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/timed_curtain_position_controller_unit.sv @@
// timed curtain position controller: an accepted command enters the input register, then
// the state update writes the result register; throughput one item per cycle unless res.ready
// holds the result, set by the combinational state update between the two registers
// reset (arst_n low, asynchronous): stopped, position and target 50, led off,
// up_step 10, down_step 12, led_enable 1; both pipeline stages empty
module timed_curtain_position_controller_unit import ctpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ctpc_in_if.sink           cmd,
	ctpc_out_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t              cfg;
	state_t            st_q;
	state_t            st_nxt;
	state_t            res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic [ACT_W-1:0]  action_s1;
	logic [GEST_W-1:0] gesture_s1;
	logic [TVAL_W-1:0] target_value_s1;
	logic              advance;

	ctpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctpc_update u_update (
		.cfg          (cfg),
		.cur          (st_q),
		.action       (action_s1),
		.gesture      (gesture_s1),
		.target_value (target_value_s1),
		.nxt          (st_nxt)
	);

	// stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 & (~valid_s2 | res.ready);
	assign cmd.ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			action_s1       <= cmd.action;
			gesture_s1      <= cmd.gesture;
			target_value_s1 <= cmd.target_value;
		end
	end

	// controller state, committed as the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.motion   <= MOT_STOP;
			st_q.position <= HOME_PCT;
			st_q.target   <= HOME_PCT;
			st_q.led      <= 1'b0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= st_nxt;
		end
	end

	// result fields
	assign res.valid    = valid_s2;
	assign res.motion   = res_s2.motion;
	assign res.drive_a  = (res_s2.motion == MOT_LOWER);
	assign res.drive_b  = (res_s2.motion == MOT_RAISE);
	assign res.led_on   = res_s2.led;
	assign res.position = res_s2.position;
	assign res.target   = res_s2.target;

`ifndef SYNTHESIS
	// estimate and target stay within the travel range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.position <= FULL_PCT && st_q.target <= FULL_PCT)
		else $error("position or target out of range");

	// the led is never lit while the motor is stopped
	a_led_stop: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.motion == MOT_STOP |-> !st_q.led)
		else $error("led lit while stopped");

	// a committed item leaves its result equal to the new state
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 && res_s2 == st_q)
		else $error("result register does not match committed state");
`endif

endmodule
